[rtl/crfdt_pkg.sv]
`timescale 1ns / 1ps

package crfdt_pkg;

  localparam int COORD_W = 11;

  localparam logic [2:0] CMD_FILL    = 3'd0;
  localparam logic [2:0] CMD_OUTLINE = 3'd1;
  localparam logic [2:0] CMD_CLEAR   = 3'd2;
  localparam logic [2:0] CMD_READ    = 3'd3;
  localparam logic [2:0] CMD_TAKE    = 3'd4;

  typedef struct packed {
    logic               start;
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [17:0] w;
    logic signed [17:0] h;
  } req_t;

  typedef struct packed {
    logic               done;
    logic               hit;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
  } stat_t;

  typedef struct packed {
    logic               hit;
    logic [COORD_W-1:0] lo;
    logic [COORD_W-1:0] hi;
  } clip_t;

  // clip one axis of a span to [0, limit)
  function automatic clip_t crfdt_clip(input logic signed [17:0] pos,
                                       input logic signed [17:0] len,
                                       input logic [11:0] limit);
    clip_t r;
    logic signed [18:0] p;
    logic signed [18:0] e;
    logic signed [18:0] lim;
    logic signed [18:0] lo;
    logic signed [18:0] en;
    logic signed [18:0] last;
    p     = {pos[17], pos};
    e     = p + {len[17], len};
    lim   = $signed({7'b0, limit});
    lo    = p[18] ? 19'sd0 : p;
    en    = (e > lim) ? lim : e;
    last  = en - 19'sd1;
    r.hit = !len[17] && (len != 18'sd0) && (en > lo);
    r.lo  = lo[COORD_W-1:0];
    r.hi  = last[COORD_W-1:0];
    return r;
  endfunction

endpackage

[rtl/clipped_rect_fill_dirty_tracker_unit.sv]
`timescale 1ns / 1ps

// Frame-store rectangle engine with dirty-box tracking. One command item in,
// one result item out. Every frame-store access goes through the frame
// memory's one write port and one read port, one word per cycle. A fill
// writes its clipped area, an outline its four clipped edges in turn (top,
// bottom, left, right) and a clear the whole canvas; a read pixel reads one
// word unless it is off the canvas, and take dirty box, an unknown command
// or an outline of zero or negative size write nothing. After reset the
// store is swept to zero, one word per cycle, with in_tready low; the whole
// canvas starts out dirty. A finished result waits in an output register,
// so the next command is taken while it is still pending; a command
// finishing while that result is still unaccepted holds until out_tready
// frees the register.
module clipped_rect_fill_dirty_tracker_unit
  import crfdt_pkg::*;
#(
  parameter int CANVAS_WIDTH  = 240,
  parameter int CANVAS_HEIGHT = 320
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // rect_x, rect_y, rect_w, rect_h, color
  input  logic [2:0]  in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // pixel_word, dirty_left, dirty_top, dirty_right,
                                  // dirty_bottom, zero pad
  output logic [1:0]  out_tuser   // off_canvas, dirty_valid
);

  localparam int DEPTH = CANVAS_WIDTH * CANVAS_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0]      W_A   = AW'(CANVAS_WIDTH);
  localparam logic signed [16:0] W17   = 17'(CANVAS_WIDTH);
  localparam logic signed [16:0] H17   = 17'(CANVAS_HEIGHT);
  localparam logic signed [17:0] W18   = 18'(CANVAS_WIDTH);
  localparam logic signed [17:0] H18   = 18'(CANVAS_HEIGHT);
  localparam logic [COORD_W-1:0] MAX_X = COORD_W'(CANVAS_WIDTH - 1);
  localparam logic [COORD_W-1:0] MAX_Y = COORD_W'(CANVAS_HEIGHT - 1);

  typedef enum logic [8:0] {
    S_CLR_GO    = 9'b000000001,
    S_CLR_WAIT  = 9'b000000010,
    S_IDLE      = 9'b000000100,
    S_EDGE_GO   = 9'b000001000,
    S_EDGE_WAIT = 9'b000010000,
    S_RD_MUL    = 9'b000100000,
    S_RD_ISSUE  = 9'b001000000,
    S_RD_WAIT   = 9'b010000000,
    S_DONE      = 9'b100000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [2:0]         cmd_r;
  logic signed [15:0] x_r, y_r, w_r, h_r;
  logic [15:0]        wire_r, pix_r;
  logic               off_r;
  logic [1:0]         edge_r;
  logic [AW-1:0]      rd_base_r;
  logic               box_valid_r;
  logic [COORD_W-1:0] box_left_r, box_top_r, box_right_r, box_bottom_r;
  logic               out_tvalid_r;
  logic [55:0]        out_tdata_r;
  logic [1:0]         out_tuser_r;

  req_t               req;
  stat_t              stat;
  logic               in_acc, out_free, last_edge, off_pix, draw_ok;
  logic signed [17:0] xe, ye, we, he;
  logic               wr_en, rd_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [15:0]        rd_data;
  logic [15:0]        bl, bt, br, bb;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_tvalid_r || out_tready;
  assign last_edge = (cmd_r != CMD_OUTLINE) || (edge_r == 2'd3);
  assign off_pix   = x_r[15] || y_r[15] || ({x_r[15], x_r} >= W17) || ({y_r[15], y_r} >= H17);
  assign draw_ok   = !in_tdata[47] && (in_tdata[47:32] != 16'd0)
                     && !in_tdata[63] && (in_tdata[63:48] != 16'd0);

  assign xe = {{2{x_r[15]}}, x_r};
  assign ye = {{2{y_r[15]}}, y_r};
  assign we = {{2{w_r[15]}}, w_r};
  assign he = {{2{h_r[15]}}, h_r};

  always_comb begin
    req.start = (state_r == S_EDGE_GO) || (state_r == S_CLR_GO);
    req.x     = xe;
    req.y     = ye;
    req.w     = we;
    req.h     = he;
    if (state_r == S_CLR_GO || cmd_r == CMD_CLEAR) begin
      req.x = 18'sd0;
      req.y = 18'sd0;
      req.w = W18;
      req.h = H18;
    end else if (cmd_r == CMD_OUTLINE) begin
      case (edge_r)
        2'd0: req.h = 18'sd1;
        2'd1: begin
          req.y = ye + he - 18'sd1;
          req.h = 18'sd1;
        end
        2'd2: req.w = 18'sd1;
        default: begin
          req.x = xe + we - 18'sd1;
          req.w = 18'sd1;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR_GO:   state_nxt = S_CLR_WAIT;
      S_CLR_WAIT: if (stat.done) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            CMD_FILL, CMD_CLEAR: state_nxt = S_EDGE_GO;
            CMD_OUTLINE:         state_nxt = draw_ok ? S_EDGE_GO : S_DONE;
            CMD_READ:            state_nxt = S_RD_MUL;
            default:             state_nxt = S_DONE;
          endcase
        end
      end
      S_EDGE_GO:   state_nxt = S_EDGE_WAIT;
      S_EDGE_WAIT: if (stat.done) state_nxt = last_edge ? S_DONE : S_EDGE_GO;
      S_RD_MUL:    state_nxt = off_pix ? S_DONE : S_RD_ISSUE;
      S_RD_ISSUE:  state_nxt = S_RD_WAIT;
      S_RD_WAIT:   state_nxt = S_DONE;
      S_DONE:      if (out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_CLR_GO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR_GO;
      box_valid_r  <= 1'b1;
      box_left_r   <= '0;
      box_top_r    <= '0;
      box_right_r  <= MAX_X;
      box_bottom_r <= MAX_Y;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_EDGE_WAIT && stat.done && stat.hit) begin
        box_valid_r <= 1'b1;
        if (!box_valid_r || stat.left < box_left_r) box_left_r <= stat.left;
        if (!box_valid_r || stat.top < box_top_r) box_top_r <= stat.top;
        if (!box_valid_r || stat.right > box_right_r) box_right_r <= stat.right;
        if (!box_valid_r || stat.bottom > box_bottom_r) box_bottom_r <= stat.bottom;
      end
      if (state_r == S_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
        if (cmd_r == CMD_TAKE) begin
          box_valid_r  <= 1'b0;
          box_left_r   <= '0;
          box_top_r    <= '0;
          box_right_r  <= '0;
          box_bottom_r <= '0;
        end
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign bl = box_valid_r ? 16'(box_left_r) : 16'd0;
  assign bt = box_valid_r ? 16'(box_top_r) : 16'd0;
  assign br = box_valid_r ? 16'(box_right_r) : 16'd0;
  assign bb = box_valid_r ? 16'(box_bottom_r) : 16'd0;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= in_tuser;
      x_r    <= in_tdata[15:0];
      y_r    <= in_tdata[31:16];
      w_r    <= in_tdata[47:32];
      h_r    <= in_tdata[63:48];
      wire_r <= {in_tdata[71:64], in_tdata[79:72]};
      edge_r <= 2'd0;
      pix_r  <= 16'd0;
      off_r  <= 1'b0;
    end
    if (state_r == S_EDGE_WAIT && stat.done) begin
      edge_r <= edge_r + 2'd1;
    end
    if (state_r == S_RD_MUL) begin
      off_r     <= off_pix;
      rd_base_r <= AW'(y_r[COORD_W-1:0]) * W_A;
    end
    if (state_r == S_RD_WAIT) begin
      pix_r <= rd_data;
    end
    if (state_r == S_DONE && out_free) begin
      out_tdata_r <= {6'd0, bb[8:0], br[7:0], bt[8:0], bl[7:0], pix_r};
      out_tuser_r <= {box_valid_r, off_r};
    end
  end

  assign rd_en   = (state_r == S_RD_ISSUE);
  assign rd_addr = rd_base_r + AW'(x_r[COORD_W-1:0]);

  crfdt_raster #(
    .CANVAS_WIDTH (CANVAS_WIDTH),
    .CANVAS_HEIGHT(CANVAS_HEIGHT),
    .AW           (AW)
  ) u_raster (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .stat   (stat),
    .wr_en  (wr_en),
    .wr_addr(wr_addr)
  );

  crfdt_frame_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data((state_r == S_CLR_WAIT) ? 16'd0 : wire_r),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_DONE))
    else $error("result item appeared without a finished command");
  a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !wr_en)
    else $error("frame store read and write in the same cycle");
  a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    box_valid_r |-> (box_left_r <= box_right_r) && (box_top_r <= box_bottom_r)
                    && (box_right_r <= MAX_X) && (box_bottom_r <= MAX_Y))
    else $error("dirty box corners out of order");

endmodule

[rtl/crfdt_frame_mem.sv]
`timescale 1ns / 1ps

module crfdt_frame_mem #(
  parameter int DEPTH = 76800,
  parameter int AW    = 17
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_data
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/crfdt_raster.sv]
`timescale 1ns / 1ps

module crfdt_raster
  import crfdt_pkg::*;
#(
  parameter int CANVAS_WIDTH  = 240,
  parameter int CANVAS_HEIGHT = 320,
  parameter int AW            = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  req_t          req,
  output stat_t         stat,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr
);

  typedef enum logic [3:0] {
    R_IDLE = 4'b0001,
    R_MUL  = 4'b0010,
    R_PREP = 4'b0100,
    R_RUN  = 4'b1000
  } rstate_t;

  localparam logic [AW-1:0] W_A = AW'(CANVAS_WIDTH);

  rstate_t            state_r, state_nxt;
  clip_t              cx, cy;
  logic               hit_r, done_r;
  logic [COORD_W-1:0] lo_x_r, hi_x_r, lo_y_r, hi_y_r;
  logic [COORD_W-1:0] col_r, row_r;
  logic [AW-1:0]      base_r, addr_r, step_r;
  logic               row_end, last_px;

  assign cx      = crfdt_clip(req.x, req.w, 12'(CANVAS_WIDTH));
  assign cy      = crfdt_clip(req.y, req.h, 12'(CANVAS_HEIGHT));
  assign row_end = (col_r == hi_x_r);
  assign last_px = row_end && (row_r == hi_y_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      R_IDLE:  if (req.start) state_nxt = R_MUL;
      R_MUL:   state_nxt = hit_r ? R_PREP : R_IDLE;
      R_PREP:  state_nxt = R_RUN;
      R_RUN:   if (last_px) state_nxt = R_IDLE;
      default: state_nxt = R_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      done_r  <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= ((state_r == R_MUL) && !hit_r) || ((state_r == R_RUN) && last_px);
      if (state_r == R_IDLE && req.start) begin
        hit_r <= cx.hit && cy.hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      R_IDLE: begin
        lo_x_r <= cx.lo;
        hi_x_r <= cx.hi;
        lo_y_r <= cy.lo;
        hi_y_r <= cy.hi;
      end
      R_MUL: begin
        base_r <= AW'(lo_y_r) * W_A;
      end
      R_PREP: begin
        addr_r <= base_r + AW'(lo_x_r);
        col_r  <= lo_x_r;
        row_r  <= lo_y_r;
        step_r <= W_A - AW'(hi_x_r - lo_x_r);
      end
      R_RUN: begin
        if (row_end) begin
          col_r  <= lo_x_r;
          row_r  <= row_r + 1'b1;
          addr_r <= addr_r + step_r;
        end else begin
          col_r  <= col_r + 1'b1;
          addr_r <= addr_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign wr_en       = (state_r == R_RUN);
  assign wr_addr     = addr_r;
  assign stat.done   = done_r;
  assign stat.hit    = hit_r;
  assign stat.left   = lo_x_r;
  assign stat.top    = lo_y_r;
  assign stat.right  = hi_x_r;
  assign stat.bottom = hi_y_r;

  a_write_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (col_r <= hi_x_r) && (row_r <= hi_y_r) && (row_r < COORD_W'(CANVAS_HEIGHT)))
    else $error("raster write outside clipped span");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("raster done held longer than one cycle");

endmodule
